[src/pclt_pkg.sv]
// Shared types, codes and constants for the printer escape-sequence tokenizer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package pclt_pkg;

    localparam int VALUE_CHARS_MAX_DEF = 63;
    localparam int COUNT_MAX_DEF       = 32767;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] GROUP_LO   = 8'h21;
    localparam logic [7:0] GROUP_HI   = 8'h2F;
    localparam logic [7:0] SUB_LO     = 8'h60;
    localparam logic [7:0] SUB_HI     = 8'h7E;
    localparam logic [7:0] DEL_BYTE   = 8'h7F;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    localparam logic [14:0] SAT_VALUE = 15'd32767;

    typedef enum logic [2:0] {
        KIND_PRINT   = 3'd0,
        KIND_CTRL    = 3'd1,
        KIND_CMD     = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_RESET   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        MODE_TEXT     = 3'd0,
        MODE_ESC      = 3'd1,
        MODE_SUBGROUP = 3'd2,
        MODE_PARAM    = 3'd3,
        MODE_PAYLOAD  = 3'd4,
        MODE_DISPLAY  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        PTYPE_NONE        = 2'd0,
        PTYPE_RASTER      = 2'd1,
        PTYPE_TRANSPARENT = 2'd2,
        PTYPE_DOWNLOAD    = 2'd3
    } ptype_t;

    // Control from the sequencer to the number accumulator.
    typedef struct packed {
        logic clear;
        logic take;
    } num_ctl_t;

    // Value of the number collected so far, in output form.
    typedef struct packed {
        logic        negative;
        logic [14:0] whole;
        logic [9:0]  thousandths;
        logic [15:0] rounded;
    } num_val_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [5:0]  group_char;
        logic [6:0]  subgroup_char;
        logic [6:0]  term_char;
        logic        value_negative;
        logic [14:0] value_whole;
        logic [9:0]  value_thousandths;
        logic [15:0] value_rounded;
        logic        payload_kind;
        logic        payload_last;
    } token_t;

endpackage

`default_nettype wire

[src/pclt_number.sv]
// Number accumulator: sign, saturated integer part, three fraction digits.
// Depends on pclt_pkg for the control and value structs.
`timescale 1ns / 1ps
`default_nettype none

module pclt_number #(
    parameter int VALUE_CHARS_MAX = pclt_pkg::VALUE_CHARS_MAX_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pclt_pkg::num_ctl_t ctl,
    input  wire logic [7:0]         num_char,
    output pclt_pkg::num_val_t      val
);

    localparam int CW = $clog2(VALUE_CHARS_MAX + 1);

    logic        sign_reg, sign_next;
    logic [14:0] int_reg, int_next;
    logic [9:0]  frac_reg, frac_next;
    logic [1:0]  fcnt_reg, fcnt_next;
    logic        point_reg, point_next;
    logic        ended_reg, ended_next;
    logic        digit_reg, digit_next;
    logic [3:0]  first_reg, first_next;
    logic [CW-1:0] ccnt_reg, ccnt_next;

    logic [3:0]  digit;
    logic [18:0] int_prod;
    logic [15:0] mag_wide;
    logic [14:0] mag;

    assign digit    = num_char[3:0] - 4'd0;
    assign int_prod = {4'd0, int_reg} * 19'd10 + {15'd0, digit};

    always_comb begin
        sign_next  = sign_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        point_next = point_reg;
        ended_next = ended_reg;
        digit_next = digit_reg;
        first_next = first_reg;
        ccnt_next  = ccnt_reg;
        if (ctl.clear) begin
            sign_next  = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            fcnt_next  = '0;
            point_next = 1'b0;
            ended_next = 1'b0;
            digit_next = 1'b0;
            first_next = '0;
            ccnt_next  = '0;
        end else if (ctl.take && (ccnt_reg != CW'(VALUE_CHARS_MAX))) begin
            ccnt_next = ccnt_reg + 1'b1;
            if (!ended_reg) begin
                if (num_char == "-" || num_char == "+") begin
                    // Sign only counts as the first character.
                    if (ccnt_reg == '0) begin
                        sign_next = (num_char == "-");
                    end else begin
                        ended_next = 1'b1;
                    end
                end else if (num_char == ".") begin
                    if (point_reg) begin
                        ended_next = 1'b1;
                    end else begin
                        point_next = 1'b1;
                    end
                end else begin
                    digit_next = 1'b1;
                    if (!point_reg) begin
                        int_next = (int_prod > {4'd0, pclt_pkg::SAT_VALUE})
                                 ? pclt_pkg::SAT_VALUE : int_prod[14:0];
                    end else if (fcnt_reg != 2'd3) begin
                        if (fcnt_reg == 2'd0) begin
                            first_next = digit;
                        end
                        frac_next = frac_reg * 10'd10 + {6'd0, digit};
                        fcnt_next = fcnt_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_reg  <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            point_reg <= 1'b0;
            ended_reg <= 1'b0;
            digit_reg <= 1'b0;
            first_reg <= '0;
            ccnt_reg  <= '0;
        end else begin
            sign_reg  <= sign_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            point_reg <= point_next;
            ended_reg <= ended_next;
            digit_reg <= digit_next;
            first_reg <= first_next;
            ccnt_reg  <= ccnt_next;
        end
    end

    // Round half away from zero on the first fraction digit, then saturate.
    assign mag_wide = {1'b0, int_reg} + {15'd0, (first_reg >= 4'd5)};
    assign mag      = (mag_wide > {1'b0, pclt_pkg::SAT_VALUE})
                    ? pclt_pkg::SAT_VALUE : mag_wide[14:0];

    always_comb begin
        val.negative = sign_reg & digit_reg;
        val.whole    = int_reg;
        unique case (fcnt_reg)
            2'd0:    val.thousandths = '0;
            2'd1:    val.thousandths = frac_reg * 10'd100;
            2'd2:    val.thousandths = frac_reg * 10'd10;
            default: val.thousandths = frac_reg;
        endcase
        val.rounded = val.negative ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    end

endmodule

`default_nettype wire

[src/pclt_parser.sv]
// Sequencer: parse mode, held group/subgroup, payload counter, token build.
// Depends on pclt_pkg and instantiates pclt_number.
`timescale 1ns / 1ps
`default_nettype none

module pclt_parser #(
    parameter int VALUE_CHARS_MAX = pclt_pkg::VALUE_CHARS_MAX_DEF,
    parameter int COUNT_MAX       = pclt_pkg::COUNT_MAX_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    output logic            emit,
    output pclt_pkg::token_t tok
);

    localparam int BW = $clog2(COUNT_MAX + 1);

    pclt_pkg::mode_t  mode_reg, mode_next;
    pclt_pkg::ptype_t ptype_reg, ptype_next;
    logic [5:0]    group_reg, group_next;
    logic [6:0]    sub_reg, sub_next;
    logic [BW-1:0] rem_reg, rem_next;

    pclt_pkg::num_ctl_t ctl;
    pclt_pkg::num_val_t val;

    pclt_number #(
        .VALUE_CHARS_MAX(VALUE_CHARS_MAX)
    ) u_number (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .num_char(in_byte),
        .val     (val)
    );

    logic          is_ctrl;
    logic          is_num;
    logic          is_upper;
    logic          is_lower;
    logic [6:0]    term;
    pclt_pkg::ptype_t cmd_ptype;
    logic [16:0]   cnt_wide;
    logic [BW-1:0] rem_dec;

    assign is_ctrl  = (in_byte < pclt_pkg::SPACE_BYTE) || (in_byte == pclt_pkg::DEL_BYTE);
    assign is_num   = ((in_byte >= "0") && (in_byte <= "9")) || (in_byte == ".")
                   || (in_byte == "-") || (in_byte == "+");
    assign is_upper = ((in_byte >= "A") && (in_byte <= "Z")) || (in_byte == "@");
    assign is_lower = (in_byte >= "a") && (in_byte <= "z");
    assign term     = is_lower ? (in_byte[6:0] - 7'h20) : in_byte[6:0];
    assign rem_dec  = rem_reg - BW'(rem_reg != '0);

    always_comb begin
        priority if ((group_reg == 6'h28 || group_reg == 6'h29) && sub_reg == "s"
                     && term == "W") begin
            cmd_ptype = pclt_pkg::PTYPE_DOWNLOAD;
        end else if (group_reg == 6'h26 && sub_reg == "p" && term == "X") begin
            cmd_ptype = pclt_pkg::PTYPE_TRANSPARENT;
        end else if (group_reg == 6'h2A && sub_reg == "b" && term == "W") begin
            cmd_ptype = pclt_pkg::PTYPE_RASTER;
        end else begin
            cmd_ptype = pclt_pkg::PTYPE_NONE;
        end
        cnt_wide = val.negative ? 17'd0 : {2'd0, val.rounded[14:0]};
        if (cnt_wide > 17'(COUNT_MAX)) begin
            cnt_wide = 17'(COUNT_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pclt_pkg::MODE_TEXT;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptype_reg <= pclt_pkg::PTYPE_NONE;
            group_reg <= '0;
            sub_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            ptype_reg <= ptype_next;
            group_reg <= group_next;
            sub_reg   <= sub_next;
            rem_reg   <= rem_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        ptype_next = ptype_reg;
        group_next = group_reg;
        sub_next   = sub_reg;
        rem_next   = rem_reg;
        ctl        = '0;
        emit       = 1'b0;
        tok        = '0;
        tok.kind   = pclt_pkg::KIND_PRINT;

        unique case (mode_reg)
            pclt_pkg::MODE_ESC: begin
                if (in_byte == "E") begin
                    emit       = 1'b1;
                    tok.kind   = pclt_pkg::KIND_RESET;
                    mode_next  = pclt_pkg::MODE_TEXT;
                    ptype_next = pclt_pkg::PTYPE_NONE;
                    group_next = '0;
                    sub_next   = '0;
                    rem_next   = '0;
                    ctl.clear  = 1'b1;
                end else if (in_byte == "Y") begin
                    mode_next = pclt_pkg::MODE_DISPLAY;
                end else if (in_byte >= pclt_pkg::GROUP_LO
                             && in_byte <= pclt_pkg::GROUP_HI) begin
                    group_next = in_byte[5:0];
                    mode_next  = pclt_pkg::MODE_SUBGROUP;
                end else begin
                    mode_next = pclt_pkg::MODE_TEXT;
                end
            end
            pclt_pkg::MODE_SUBGROUP: begin
                if (in_byte >= pclt_pkg::SUB_LO && in_byte <= pclt_pkg::SUB_HI) begin
                    sub_next  = in_byte[6:0];
                    ctl.clear = 1'b1;
                    mode_next = pclt_pkg::MODE_PARAM;
                end else begin
                    mode_next = pclt_pkg::MODE_TEXT;
                end
            end
            pclt_pkg::MODE_PARAM: begin
                if (is_num) begin
                    ctl.take = 1'b1;
                end else if (is_upper || is_lower) begin
                    emit                  = 1'b1;
                    tok.kind              = pclt_pkg::KIND_CMD;
                    tok.group_char        = group_reg;
                    tok.subgroup_char     = sub_reg;
                    tok.term_char         = term;
                    tok.value_negative    = val.negative;
                    tok.value_whole       = val.whole;
                    tok.value_thousandths = val.thousandths;
                    tok.value_rounded     = val.rounded;
                    if (cmd_ptype != pclt_pkg::PTYPE_NONE) begin
                        if (cnt_wide == '0) begin
                            mode_next = pclt_pkg::MODE_TEXT;
                        end else begin
                            mode_next  = pclt_pkg::MODE_PAYLOAD;
                            ptype_next = cmd_ptype;
                            rem_next   = cnt_wide[BW-1:0];
                        end
                    end else if (is_lower) begin
                        // Chain: next value in the same group.
                        ctl.clear = 1'b1;
                    end else begin
                        mode_next = pclt_pkg::MODE_TEXT;
                    end
                end else begin
                    mode_next = pclt_pkg::MODE_TEXT;
                end
            end
            pclt_pkg::MODE_PAYLOAD: begin
                emit             = 1'b1;
                rem_next         = rem_dec;
                tok.data_byte    = in_byte;
                tok.payload_last = (rem_dec == '0);
                if (ptype_reg == pclt_pkg::PTYPE_TRANSPARENT) begin
                    tok.kind = is_ctrl ? pclt_pkg::KIND_CTRL : pclt_pkg::KIND_PRINT;
                end else begin
                    tok.kind         = pclt_pkg::KIND_PAYLOAD;
                    tok.payload_kind = (ptype_reg == pclt_pkg::PTYPE_DOWNLOAD);
                end
                if (rem_dec == '0) begin
                    mode_next  = pclt_pkg::MODE_TEXT;
                    ptype_next = pclt_pkg::PTYPE_NONE;
                end
            end
            pclt_pkg::MODE_TEXT, pclt_pkg::MODE_DISPLAY: begin
                if (in_byte == pclt_pkg::ESC_BYTE) begin
                    mode_next = pclt_pkg::MODE_ESC;
                end else begin
                    emit          = 1'b1;
                    tok.kind      = is_ctrl ? pclt_pkg::KIND_CTRL : pclt_pkg::KIND_PRINT;
                    tok.data_byte = in_byte;
                end
            end
            default: begin
                mode_next = pclt_pkg::MODE_TEXT;
            end
        endcase

        // Hold all state while no beat is being processed.
        if (!step) begin
            mode_next  = mode_reg;
            ptype_next = ptype_reg;
            group_next = group_reg;
            sub_next   = sub_reg;
            rem_next   = rem_reg;
            ctl        = '0;
        end
    end

endmodule

`default_nettype wire

[src/pcl_escape_sequence_tokenizer_core.sv]
// Top level of the printer escape-sequence tokenizer: input register,
// sequencer, result register. Depends on pclt_pkg and pclt_parser.
//
// Usage:
//   Input channel (s_valid/s_ready/s_in_byte) takes one raw stream byte per
//   beat. Result channel (m_valid/m_ready/m_*) gives at most one token per
//   input beat, in stream order; bytes that only advance the parse (escape
//   prefixes, number characters, malformed sequences) give no token.
//   Path: two register stages, input register and result register; a byte
//   accepted into the first has its token registered in the second.
//   Throughput: one byte per cycle while the result channel does not stall.
//   The per-byte parse is a single state update between the two registers.
//   Stall: while m_ready is low and a token is held, the input register
//   keeps advancing as long as its byte yields no token; a byte that does
//   yield one waits in the input register and s_ready drops. No token is
//   lost or repeated.
//   Reset: aresetn (synchronous, active low) clears both valid flags and
//   puts the parser in text mode with an empty number and no payload.
//   The ESC E sequence does the same to parser state and emits a reset
//   token.
`timescale 1ns / 1ps
`default_nettype none

module pcl_escape_sequence_tokenizer_core #(
    parameter int VALUE_CHARS_MAX = pclt_pkg::VALUE_CHARS_MAX_DEF,
    parameter int COUNT_MAX       = pclt_pkg::COUNT_MAX_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_in_byte,

    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_data_byte,
    output logic [5:0]        m_group_char,
    output logic [6:0]        m_subgroup_char,
    output logic [6:0]        m_term_char,
    output logic              m_value_negative,
    output logic [14:0]       m_value_whole,
    output logic [9:0]        m_value_thousandths,
    output logic signed [15:0] m_value_rounded,
    output logic              m_payload_kind,
    output logic              m_payload_last
);

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             out_vld_reg;
    pclt_pkg::token_t out_tok_reg;

    logic             emit;
    logic             step;
    pclt_pkg::token_t tok;

    pclt_parser #(
        .VALUE_CHARS_MAX(VALUE_CHARS_MAX),
        .COUNT_MAX      (COUNT_MAX)
    ) u_parser (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .in_byte(in_byte_reg),
        .emit   (emit),
        .tok    (tok)
    );

    // Advance the held byte unless its token would overwrite one still waiting.
    assign step    = in_vld_reg && (!emit || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step && emit) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_tok_reg <= tok;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_kind              = out_tok_reg.kind;
    assign m_data_byte         = out_tok_reg.data_byte;
    assign m_group_char        = out_tok_reg.group_char;
    assign m_subgroup_char     = out_tok_reg.subgroup_char;
    assign m_term_char         = out_tok_reg.term_char;
    assign m_value_negative    = out_tok_reg.value_negative;
    assign m_value_whole       = out_tok_reg.value_whole;
    assign m_value_thousandths = out_tok_reg.value_thousandths;
    assign m_value_rounded     = $signed(out_tok_reg.value_rounded);
    assign m_payload_kind      = out_tok_reg.payload_kind;
    assign m_payload_last      = out_tok_reg.payload_last;

endmodule

`default_nettype wire

[tb/tb_pcl_escape_sequence_tokenizer_core.sv]
// Self-checking testbench for pcl_escape_sequence_tokenizer_core: a directed table of byte
// strings, then ~1000 random stream bytes, all scored against a cycle-free token predictor.
// Depends on pclt_pkg and the core; needs no files, arguments or other sources.
`timescale 1ns / 1ps

module tb_pcl_escape_sequence_tokenizer_core;

    localparam int RANDOM_BYTES = 1000;
    localparam int SAT_MAG      = 32767;

    // One row of the directed table: a byte string, and optionally the token that its
    // last byte must give. An empty string stands for the single byte 0x00.
    typedef struct {
        string            txt;
        bit               typed;
        pclt_pkg::token_t exp;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [7:0]   s_in_byte;
    logic         m_valid;
    logic         m_ready;
    logic [2:0]   m_kind;
    logic [7:0]   m_data_byte;
    logic [5:0]   m_group_char;
    logic [6:0]   m_subgroup_char;
    logic [6:0]   m_term_char;
    logic         m_value_negative;
    logic [14:0]  m_value_whole;
    logic [9:0]   m_value_thousandths;
    logic signed [15:0] m_value_rounded;
    logic         m_payload_kind;
    logic         m_payload_last;

    pcl_escape_sequence_tokenizer_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_in_byte           (s_in_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_data_byte         (m_data_byte),
        .m_group_char        (m_group_char),
        .m_subgroup_char     (m_subgroup_char),
        .m_term_char         (m_term_char),
        .m_value_negative    (m_value_negative),
        .m_value_whole       (m_value_whole),
        .m_value_thousandths (m_value_thousandths),
        .m_value_rounded     (m_value_rounded),
        .m_payload_kind      (m_payload_kind),
        .m_payload_last      (m_payload_last)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the tokenizer state, advanced once per accepted beat
    // ------------------------------------------------------------------
    pclt_pkg::mode_t  sh_mode;
    logic [7:0]       sh_group;
    logic [7:0]       sh_subgroup;
    bit               sh_minus;
    bit               sh_point;
    bit               sh_ended;
    bit               sh_digit;
    int               sh_whole;
    int               sh_frac;
    int               sh_frac_n;
    int               sh_first_frac;
    int               sh_chars;
    int               sh_left;
    pclt_pkg::ptype_t sh_ptype;

    // Tokens predicted but not yet seen on the result channel, oldest first.
    pclt_pkg::token_t pending_tokens[$];

    dir_row_t    dir_rows[$];
    logic [7:0]  gen_q[$];

    // Typed expectation attached to the beat currently offered.
    bit               cur_typed;
    pclt_pkg::token_t cur_exp;

    int          errors;
    int          tokens_checked;
    int          cmd_seen;
    int          payload_seen;
    int          reset_seen;
    int          bytes_sent;
    int          hold_cnt;
    int          burst_left;
    bit          tx_steady;

    function automatic void clear_value();
        sh_minus      = 1'b0;
        sh_point      = 1'b0;
        sh_ended      = 1'b0;
        sh_digit      = 1'b0;
        sh_whole      = 0;
        sh_frac       = 0;
        sh_frac_n     = 0;
        sh_first_frac = 0;
        sh_chars      = 0;
    endfunction

    function automatic void shadow_reset();
        sh_mode     = pclt_pkg::MODE_TEXT;
        sh_group    = 8'h00;
        sh_subgroup = 8'h00;
        sh_left     = 0;
        sh_ptype    = pclt_pkg::PTYPE_NONE;
        clear_value();
    endfunction

    function automatic pclt_pkg::token_t make_token(pclt_pkg::kind_t k, logic [7:0] d,
                                          logic [5:0] g,
                                          logic [6:0] sg, logic [6:0] tc, logic neg,
                                          logic [14:0] whole, logic [9:0] thou,
                                          logic [15:0] rnd, logic pk, logic pl);
        pclt_pkg::token_t t;
        t.kind              = k;
        t.data_byte         = d;
        t.group_char        = g;
        t.subgroup_char     = sg;
        t.term_char         = tc;
        t.value_negative    = neg;
        t.value_whole       = whole;
        t.value_thousandths = thou;
        t.value_rounded     = rnd;
        t.payload_kind      = pk;
        t.payload_last      = pl;
        return t;
    endfunction

    function automatic pclt_pkg::token_t pass_token(logic [7:0] b);
        pclt_pkg::token_t t;
        t = '0;
        t.kind = (b < pclt_pkg::SPACE_BYTE || b == pclt_pkg::DEL_BYTE)
               ? pclt_pkg::KIND_CTRL : pclt_pkg::KIND_PRINT;
        t.data_byte = b;
        return t;
    endfunction

    // Fold one number character into the value, atof style.
    function automatic void take_number_char(logic [7:0] b);
        int d;
        if (sh_chars >= pclt_pkg::VALUE_CHARS_MAX_DEF) return;
        sh_chars++;
        if (sh_ended) return;
        if (b == "-" || b == "+") begin
            if (sh_chars == 1) sh_minus = (b == "-");
            else sh_ended = 1'b1;
        end else if (b == ".") begin
            if (sh_point) sh_ended = 1'b1;
            else sh_point = 1'b1;
        end else begin
            d = b - "0";
            sh_digit = 1'b1;
            if (!sh_point) begin
                sh_whole = sh_whole * 10 + d;
                if (sh_whole > SAT_MAG) sh_whole = SAT_MAG;
            end else if (sh_frac_n < 3) begin
                if (sh_frac_n == 0) sh_first_frac = d;
                sh_frac = sh_frac * 10 + d;
                sh_frac_n++;
            end
        end
    endfunction

    // Build the command token for a terminator and decide what follows it.
    function automatic pclt_pkg::token_t issue_command(logic [7:0] term, bit chain);
        pclt_pkg::token_t t;
        bit               neg;
        int               thou;
        int               mag;
        int               cnt;
        int               signed_mag;
        pclt_pkg::ptype_t pt;
        neg  = sh_minus && sh_digit;
        thou = sh_frac;
        for (int i = sh_frac_n; i < 3; i++) thou = thou * 10;
        mag = sh_whole + ((sh_first_frac >= 5) ? 1 : 0);
        if (mag > SAT_MAG) mag = SAT_MAG;
        signed_mag = neg ? -mag : mag;
        t = '0;
        t.kind              = pclt_pkg::KIND_CMD;
        t.group_char        = sh_group[5:0];
        t.subgroup_char     = sh_subgroup[6:0];
        t.term_char         = term[6:0];
        t.value_negative    = neg;
        t.value_whole       = sh_whole[14:0];
        t.value_thousandths = thou[9:0];
        t.value_rounded     = signed_mag[15:0];

        pt = pclt_pkg::PTYPE_NONE;
        if ((sh_group == "(" || sh_group == ")") && sh_subgroup == "s" && term == "W")
            pt = pclt_pkg::PTYPE_DOWNLOAD;
        else if (sh_group == "&" && sh_subgroup == "p" && term == "X")
            pt = pclt_pkg::PTYPE_TRANSPARENT;
        else if (sh_group == "*" && sh_subgroup == "b" && term == "W")
            pt = pclt_pkg::PTYPE_RASTER;

        if (pt != pclt_pkg::PTYPE_NONE) begin
            cnt = neg ? 0 : mag;
            if (cnt > pclt_pkg::COUNT_MAX_DEF) cnt = pclt_pkg::COUNT_MAX_DEF;
            if (cnt == 0) begin
                sh_mode = pclt_pkg::MODE_TEXT;
            end else begin
                sh_mode  = pclt_pkg::MODE_PAYLOAD;
                sh_ptype = pt;
                sh_left  = cnt;
            end
        end else if (chain) begin
            clear_value();
        end else begin
            sh_mode = pclt_pkg::MODE_TEXT;
        end
        return t;
    endfunction

    // Advance the shadow state by one stream byte; return 1 when a token results.
    function automatic bit tokenize_byte(input logic [7:0] b, output pclt_pkg::token_t t);
        bit last;
        t = '0;
        case (sh_mode)
            pclt_pkg::MODE_ESC: begin
                if (b == "E") begin
                    shadow_reset();
                    t.kind = pclt_pkg::KIND_RESET;
                    return 1'b1;
                end
                if (b == "Y") sh_mode = pclt_pkg::MODE_DISPLAY;
                else if (b >= pclt_pkg::GROUP_LO && b <= pclt_pkg::GROUP_HI) begin
                    sh_group = b;
                    sh_mode  = pclt_pkg::MODE_SUBGROUP;
                end else sh_mode = pclt_pkg::MODE_TEXT;
                return 1'b0;
            end
            pclt_pkg::MODE_SUBGROUP: begin
                if (b >= pclt_pkg::SUB_LO && b <= pclt_pkg::SUB_HI) begin
                    sh_subgroup = b;
                    clear_value();
                    sh_mode = pclt_pkg::MODE_PARAM;
                end else begin
                    sh_mode = pclt_pkg::MODE_TEXT;
                end
                return 1'b0;
            end
            pclt_pkg::MODE_PARAM: begin
                if ((b >= "0" && b <= "9") || b == "." || b == "-" || b == "+") begin
                    take_number_char(b);
                    return 1'b0;
                end
                if ((b >= "A" && b <= "Z") || b == "@") begin
                    t = issue_command(b, 1'b0);
                    return 1'b1;
                end
                if (b >= "a" && b <= "z") begin
                    t = issue_command(b - 8'h20, 1'b1);
                    return 1'b1;
                end
                sh_mode = pclt_pkg::MODE_TEXT;
                return 1'b0;
            end
            pclt_pkg::MODE_PAYLOAD: begin
                if (sh_left > 0) sh_left--;
                last = (sh_left == 0);
                if (sh_ptype == pclt_pkg::PTYPE_TRANSPARENT) begin
                    t = pass_token(b);
                end else begin
                    t.kind         = pclt_pkg::KIND_PAYLOAD;
                    t.data_byte    = b;
                    t.payload_kind = (sh_ptype == pclt_pkg::PTYPE_DOWNLOAD);
                end
                t.payload_last = last;
                if (last) begin
                    sh_mode  = pclt_pkg::MODE_TEXT;
                    sh_ptype = pclt_pkg::PTYPE_NONE;
                end
                return 1'b1;
            end
            default: begin
                // Text and display mode behave alike: ESC opens a sequence.
                if (b == pclt_pkg::ESC_BYTE) begin
                    sh_mode = pclt_pkg::MODE_ESC;
                    return 1'b0;
                end
                t = pass_token(b);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, and the one reset at the start of the run
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on every accepted input beat, score every
    // accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pclt_pkg::token_t t;
        pclt_pkg::token_t act;
        bit               got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                got = tokenize_byte(s_in_byte, t);
                // A typed table entry overrides the prediction for that beat.
                if (cur_typed) begin
                    t   = cur_exp;
                    got = 1'b1;
                end
                if (got) pending_tokens = {pending_tokens, t};
            end
            if (m_valid && m_ready) begin
                if (pending_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: token with no expectation: kind %0d, data 0x%0h",
                             $time, m_kind, m_data_byte);
                end else begin
                    t = pending_tokens.pop_front();
                    act = make_token(pclt_pkg::kind_t'(m_kind), m_data_byte, m_group_char,
                                     m_subgroup_char, m_term_char, m_value_negative,
                                     m_value_whole, m_value_thousandths, m_value_rounded,
                                     m_payload_kind, m_payload_last);
                    check_field("kind", t.kind, act.kind);
                    check_field("data_byte", t.data_byte, act.data_byte);
                    check_field("group_char", t.group_char, act.group_char);
                    check_field("subgroup_char", t.subgroup_char, act.subgroup_char);
                    check_field("term_char", t.term_char, act.term_char);
                    check_field("value_negative", t.value_negative, act.value_negative);
                    check_field("value_whole", t.value_whole, act.value_whole);
                    check_field("value_thousandths", t.value_thousandths,
                                act.value_thousandths);
                    check_field("value_rounded", t.value_rounded, act.value_rounded);
                    check_field("payload_kind", t.payload_kind, act.payload_kind);
                    check_field("payload_last", t.payload_last, act.payload_last);
                    tokens_checked++;
                    if (t.kind == pclt_pkg::KIND_CMD) cmd_seen++;
                    if (t.kind == pclt_pkg::KIND_PAYLOAD) payload_seen++;
                    if (t.kind == pclt_pkg::KIND_RESET) reset_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drive m_ready at the falling edge. Switch between styles
    // (always ready, random, periodic, sparse) on spans of random length;
    // hold low while a long hold-off is counting down.
    // ------------------------------------------------------------------
    initial begin
        int style;
        int span;
        m_ready = 1'b0;
        style   = 0;
        span    = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 120);
            end
            span--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ((span % 5) < 3);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Offer one beat at the falling edge and hold it until accepted. Bursts of random
    // length are separated by random gaps, except while the sender runs steady.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input pclt_pkg::token_t exp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        cur_typed = typed;
        cur_exp   = exp;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Drop valid and wait until every predicted token has come out.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        cur_typed = 1'b0;
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic add_row(input string txt, input bit typed = 1'b0,
                           input pclt_pkg::token_t exp = '0);
        dir_row_t row;
        row.txt   = txt;
        row.typed = typed;
        row.exp   = exp;
        dir_rows = {dir_rows, row};
    endtask

    // Append one byte to the stretch being generated.
    function automatic void gen_add(input logic [7:0] b);
        gen_q = {gen_q, b};
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) gen_add(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) gen_add(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    // Append one value: optional sign, digits, optional point and fraction, and now
    // and then a malformed tail or an overlong run of digits.
    task automatic gen_value();
        int n;
        case ($urandom_range(0, 3))
            1:       gen_add("-");
            2:       gen_add("+");
            default: ;
        endcase
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) n = $urandom_range(58, 70);
        push_digits(n);
        if ($urandom_range(0, 1)) begin
            gen_add(".");
            push_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       gen_add("-");
                1:       gen_add("+");
                default: gen_add(".");
            endcase
            push_digits($urandom_range(1, 3));
        end
    endtask

    // Append one random stretch of stream: text, a payload command with its data, a
    // general command chain, a two-byte escape, or noise. Some commands get broken.
    task automatic gen_sequence();
        int         r;
        int         n;
        int         cnt;
        int         st;
        bit         neg_cnt;
        logic [7:0] g;
        logic [7:0] sg;
        logic [7:0] t;
        r  = $urandom_range(0, 99);
        st = gen_q.size();
        if (r < 25) begin
            gen_add(8'($urandom_range(0, 255)));
        end else if (r < 45) begin
            gen_add(pclt_pkg::ESC_BYTE);
            case ($urandom_range(0, 3))
                0:       begin g = "("; sg = "s"; t = "W"; end
                1:       begin g = ")"; sg = "s"; t = "W"; end
                2:       begin g = "&"; sg = "p"; t = "X"; end
                default: begin g = "*"; sg = "b"; t = "W"; end
            endcase
            gen_add(g);
            gen_add(sg);
            // Chain a harmless command first now and then ('a' to 'u').
            if ($urandom_range(0, 2) == 0) begin
                gen_value();
                gen_add(8'(8'h61 + $urandom_range(0, 20)));
            end
            // Keep most payloads short; a few run to a few hundred bytes.
            cnt = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 12);
            neg_cnt = ($urandom_range(0, 9) == 0);
            push_text($sformatf(neg_cnt ? "-%0d" : "%0d", cnt));
            gen_add($urandom_range(0, 1) ? t : (t | 8'h20));
            if (!neg_cnt) repeat (cnt) gen_add(8'($urandom_range(0, 255)));
        end else if (r < 75) begin
            gen_add(pclt_pkg::ESC_BYTE);
            g  = 8'(pclt_pkg::GROUP_LO + $urandom_range(0, 14));
            sg = 8'(pclt_pkg::SUB_LO + $urandom_range(0, 30));
            gen_add(g);
            gen_add(sg);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                gen_value();
                if (i < n - 1 || $urandom_range(0, 9) == 0)
                    t = 8'(8'h61 + $urandom_range(0, 25));
                else
                    t = 8'(8'h40 + $urandom_range(0, 26));
                // Steer clear of payload starts here; they have their own branch.
                if ((g == "(" || g == ")" || g == "&" || g == "*") &&
                    ((t & 8'hDF) == "W" || (t & 8'hDF) == "X"))
                    t = (t & 8'h20) | 8'h56;
                gen_add(t);
            end
            // Break the sequence: cut it short and end it with a stray byte.
            if ($urandom_range(0, 9) == 0) begin
                cnt = $urandom_range(1, gen_q.size() - st - 1);
                while (gen_q.size() > st + cnt) void'(gen_q.pop_back());
                gen_add($urandom_range(0, 1) ? 8'h23 : 8'($urandom_range(0, 31)));
            end
        end else if (r < 88) begin
            gen_add(pclt_pkg::ESC_BYTE);
            case ($urandom_range(0, 6))
                0:       gen_add("E");
                1: begin
                    gen_add("Y");
                    repeat ($urandom_range(1, 6)) gen_add(8'($urandom_range(0, 255)));
                end
                2:       gen_add("Z");
                3:       gen_add("z");
                4:       gen_add("9");
                5:       gen_add("=");
                default: gen_add(8'($urandom_range(0, 255)));
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 5))
                    0:       gen_add(pclt_pkg::ESC_BYTE);
                    1:       gen_add(8'(8'h30 + $urandom_range(0, 9)));
                    2:       gen_add(".");
                    3:       gen_add("-");
                    4:       gen_add(8'(8'h40 + $urandom_range(0, 58)));
                    default: gen_add(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        string      lng;
        logic [7:0] b;
        int         n;
        int         rand_sent;
        bit         hold_done;
        bit         pause_done;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_in_byte  = 8'h00;
        cur_typed  = 1'b0;
        cur_exp    = '0;
        errors     = 0;
        tokens_checked = 0;
        cmd_seen   = 0;
        payload_seen = 0;
        reset_seen = 0;
        bytes_sent = 0;
        hold_cnt   = 0;
        burst_left = 0;
        tx_steady  = 1'b0;
        rand_sent  = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        shadow_reset();

        // Directed table. Typed rows give the token of their last byte outright.
        add_row("A", 1'b1,
                make_token(pclt_pkg::KIND_PRINT, "A", 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("", 1'b1,
                make_token(pclt_pkg::KIND_CTRL, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\037", 1'b1,
                make_token(pclt_pkg::KIND_CTRL, 8'h1F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(" ", 1'b1,
                make_token(pclt_pkg::KIND_PRINT, 8'h20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\176", 1'b1,
                make_token(pclt_pkg::KIND_PRINT, 8'h7E, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\177", 1'b1,
                make_token(pclt_pkg::KIND_CTRL, 8'h7F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\377", 1'b1,
                make_token(pclt_pkg::KIND_PRINT, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Saturated whole part.
        add_row("\033&l99999A", 1'b1,
                make_token(pclt_pkg::KIND_CMD, 0, 6'h26, 7'h6C, 7'h41, 0, 15'd32767, 0,
                           16'd32767, 0, 0));
        add_row("\033*p-12.3456x45.5Y");          // chained command, rounding
        add_row("\033(s+.5V");                    // fraction only
        add_row("\033&l-H");                      // sign without digits
        add_row("\033&a1-2.3.4R");                // malformed number
        add_row("\033&l12#B");                    // bad value byte
        add_row("\033Qa\033\033b");               // unknown escapes, ESC ESC too
        add_row("\033&Zc");                       // bad subgroup
        add_row("\033E", 1'b1,
                make_token(pclt_pkg::KIND_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        lng = "\033&l";
        repeat (60) lng = {lng, "0"};
        add_row({lng, "123999A"});                // digits past the character limit
        add_row("\033*b3W\001\377x");             // raster payload
        add_row("\033(s2Wab");                    // download payload
        add_row("\033)s1wZ");                     // payload after lowercase terminator
        add_row("\033&p3X\033\015q");             // transparent payload passes ESC
        add_row("\033*b0wQ\033*b-5WR");           // zero and negative lengths
        add_row("\033Y\001Q\033Zx\0339y\033=z");  // display mode, swallowed escapes
        add_row("\033&k@\033&f1.5e2.49@");        // '@' terminator
        add_row("\033!~7A\033/`3B");              // group and subgroup extremes
        add_row("\033&u-32768.9999X");            // negative saturation after rounding

        // Hold reset, then release it at a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the table.
        foreach (dir_rows[r]) begin
            n = (dir_rows[r].txt.len() == 0) ? 1 : dir_rows[r].txt.len();
            for (int i = 0; i < n; i++) begin
                b = (dir_rows[r].txt.len() == 0) ? 8'h00 : dir_rows[r].txt[i];
                send_byte(b, dir_rows[r].typed && (i == n - 1), dir_rows[r].exp);
            end
        end
        wait_idle();

        // Random stream, with one long receiver hold-off, one full drain, and a
        // stretch with no sender gaps.
        while (rand_sent < RANDOM_BYTES) begin
            if (!hold_done && rand_sent >= 250) begin
                hold_done = 1'b1;
                hold_cnt  = 400;
            end
            if (!pause_done && rand_sent >= 600) begin
                pause_done = 1'b1;
                wait_idle();
            end
            tx_steady = (rand_sent >= 750 && rand_sent < 880);
            gen_q.delete();
            gen_sequence();
            foreach (gen_q[i]) send_byte(gen_q[i], 1'b0, '0);
            rand_sent += gen_q.size();
        end

        // Drain and let the pipeline settle.
        wait_idle();

        $display("Run covered %0d stream bytes and %0d tokens: %0d commands, %0d payload bytes,",
                 bytes_sent, tokens_checked, cmd_seen, payload_seen);
        $display("%0d resets, with text, display, escape, malformed and stall cases mixed in.",
                 reset_seen);
        if (errors == 0 && pending_tokens.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: end the run well past the slowest correct finish.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
